/* rtl/core/ub8_pkg.sv */
`timescale 1ns / 1ps
package ub8_pkg;

	localparam int CELL_SIZE      = 8;
	localparam int K_W            = $clog2(CELL_SIZE);
	localparam int MAX_GRID_WIDTH = 128;
	localparam int ROW_W          = 10;
	localparam int OFFSET_W       = 24;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd2;

	localparam logic [7:0]  GRID_WIDTH_RST   = 8'd40;
	localparam logic [10:0] GRID_HEIGHT_RST  = 11'd25;
	localparam logic [15:0] SCREEN_WIDTH_RST = 16'd320;

	localparam logic [10:0] MIN_GRID_HEIGHT = 11'd2;
	localparam logic [10:0] MAX_GRID_HEIGHT = 11'd1024;

	// corners and placement of one cell, handed from the front end to the row sequencer
	typedef struct packed {
		logic [7:0]          tl;
		logic [7:0]          tr;
		logic [7:0]          bl;
		logic [7:0]          br;
		logic [OFFSET_W-1:0] base_x;
		logic [ROW_W-1:0]    row_m1;
	} cell_load_t;

	// pixel l of a row: (left + l*step) >> 3, negative values clamp to 0, over 255 to 255
	function automatic logic [7:0] pixel_of(input logic signed [11:0] left,
			input logic signed [9:0] step, input logic [K_W-1:0] l);
		logic signed [14:0] v;
		logic [14:0]        sh;
		begin
			v = $signed({{3{left[11]}}, left})
				+ $signed({{5{step[9]}}, step}) * $signed({{(15-K_W){1'b0}}, l});
			sh = 15'(v) >> 3;
			if (v < 0) begin
				pixel_of = 8'd0;
			end else if (sh > 15'd255) begin
				pixel_of = 8'd255;
			end else begin
				pixel_of = sh[7:0];
			end
		end
	endfunction

endpackage

/* rtl/core/ub8_front.sv */
`timescale 1ns / 1ps
module ub8_front #(
	parameter int MAX_GRID_WIDTH = ub8_pkg::MAX_GRID_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           sample,
	input  logic [7:0]           grid_width,
	input  logic [10:0]          grid_height,
	output logic                 load_valid,
	input  logic                 load_ready,
	output ub8_pkg::cell_load_t  load
);

	localparam int COL_W = $clog2(MAX_GRID_WIDTH);

	logic [7:0]                  line_mem [MAX_GRID_WIDTH];
	logic [7:0]                  top_rd_s1;
	logic [7:0]                  sample_s1;
	logic [COL_W-1:0]            col_s1;
	logic [ub8_pkg::ROW_W-1:0]   row_s1;
	logic                        valid_s1;

	logic [7:0]                  ul_hold_q;
	logic [7:0]                  ll_hold_q;
	logic [COL_W-1:0]            col_q;
	logic [ub8_pkg::ROW_W-1:0]   row_q;

	logic                        in_acc;
	logic                        emit;
	logic                        adv;
	logic [31:0]                 width_c;
	logic [10:0]                 height_c;
	logic                        col_last;
	logic                        row_last;

	assign in_acc = in_valid && !in_stall;
	assign emit   = (col_s1 != '0) && (row_s1 != '0);
	assign adv    = valid_s1 && (!emit || load_ready);
	assign in_stall   = valid_s1 && !adv;
	assign load_valid = valid_s1 && emit;

	always_comb begin
		load.tl     = ul_hold_q;
		load.tr     = top_rd_s1;
		load.bl     = ll_hold_q;
		load.br     = sample_s1;
		load.base_x = ub8_pkg::OFFSET_W'({col_s1 - COL_W'(1), 3'b000});
		load.row_m1 = row_s1 - ub8_pkg::ROW_W'(1);
	end

	// clamp the frame geometry
	always_comb begin
		if (grid_width < 8'd2) begin
			width_c = 32'd2;
		end else if (32'(grid_width) > 32'(MAX_GRID_WIDTH)) begin
			width_c = 32'(MAX_GRID_WIDTH);
		end else begin
			width_c = 32'(grid_width);
		end
		if (grid_height < ub8_pkg::MIN_GRID_HEIGHT) begin
			height_c = ub8_pkg::MIN_GRID_HEIGHT;
		end else if (grid_height > ub8_pkg::MAX_GRID_HEIGHT) begin
			height_c = ub8_pkg::MAX_GRID_HEIGHT;
		end else begin
			height_c = grid_height;
		end
	end

	assign col_last = 32'(col_q) >= (width_c - 32'd1);
	assign row_last = {1'b0, row_q} >= (height_c - 11'd1);

	// line store: read the old entry and overwrite it in the same cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			top_rd_s1 <= line_mem[col_q];
			line_mem[col_q] <= sample;
			sample_s1 <= sample;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			ul_hold_q <= '0;
			ll_hold_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				ul_hold_q <= top_rd_s1;
				ll_hold_q <= sample_s1;
			end
			if (in_acc) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + ub8_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

/* rtl/core/ub8_rows.sv */
`timescale 1ns / 1ps
module ub8_rows (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [15:0]                   screen_width,
	input  logic                          load_valid,
	output logic                          load_ready,
	input  ub8_pkg::cell_load_t           load,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    pix [ub8_pkg::CELL_SIZE],
	output logic [ub8_pkg::OFFSET_W-1:0]  screen_offset,
	output logic                          last_row
);

	localparam logic [ub8_pkg::K_W-1:0] LAST_K = ub8_pkg::K_W'(ub8_pkg::CELL_SIZE - 1);

	logic                            busy_s2;
	logic [ub8_pkg::K_W-1:0]         k_s2;
	logic signed [11:0]              left_s2;
	logic signed [11:0]              right_s2;
	logic signed [8:0]               dl_s2;
	logic signed [8:0]               dr_s2;
	logic [ub8_pkg::OFFSET_W-1:0]    off_s2;

	logic                            valid_s3;
	logic [7:0]                      pix_s3 [ub8_pkg::CELL_SIZE];
	logic [ub8_pkg::OFFSET_W-1:0]    off_s3;
	logic                            last_s3;

	logic                            out_free;
	logic                            row_adv;
	logic                            load_acc;
	logic [25:0]                     prod;
	logic [ub8_pkg::OFFSET_W-1:0]    off0;
	logic signed [12:0]              diff;
	logic signed [9:0]               step;

	assign out_free   = !valid_s3 || !out_stall;
	assign row_adv    = busy_s2 && out_free;
	assign load_ready = !busy_s2 || (row_adv && (k_s2 == LAST_K));
	assign load_acc   = load_valid && load_ready;

	// offset of the first row of the cell, modulo 2^24
	assign prod = 26'(load.row_m1) * 26'(screen_width);
	assign off0 = ub8_pkg::OFFSET_W'({prod, 3'b000}) + load.base_x;

	assign diff = 13'(right_s2) - 13'(left_s2);
	assign step = 10'(diff >>> 3);

	always_ff @(posedge clk) begin
		if (load_acc) begin
			left_s2  <= $signed({1'b0, load.tl, 3'b000});
			right_s2 <= $signed({1'b0, load.tr, 3'b000});
			dl_s2    <= $signed({1'b0, load.bl}) - $signed({1'b0, load.tl});
			dr_s2    <= $signed({1'b0, load.br}) - $signed({1'b0, load.tr});
			off_s2   <= off0;
		end else if (row_adv) begin
			left_s2  <= left_s2 + 12'(dl_s2);
			right_s2 <= right_s2 + 12'(dr_s2);
			off_s2   <= off_s2 + ub8_pkg::OFFSET_W'(screen_width);
		end
		if (row_adv) begin
			for (int l = 0; l < ub8_pkg::CELL_SIZE; l++) begin
				pix_s3[l] <= ub8_pkg::pixel_of(left_s2, step, ub8_pkg::K_W'(l));
			end
			off_s3  <= off_s2;
			last_s3 <= (k_s2 == LAST_K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2  <= 1'b0;
			k_s2     <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_acc) begin
				busy_s2 <= 1'b1;
				k_s2    <= '0;
			end else if (row_adv) begin
				k_s2 <= k_s2 + ub8_pkg::K_W'(1);
				if (k_s2 == LAST_K) begin
					busy_s2 <= 1'b0;
				end
			end
			if (row_adv) begin
				valid_s3 <= 1'b1;
			end else if (!out_stall) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_s3;
	assign pix           = pix_s3;
	assign screen_offset = off_s3;
	assign last_row      = last_s3;

endmodule

/* rtl/core/bilinear_upscale_by_eight_top.sv */
`timescale 1ns / 1ps
// path: front-end register, then row sequencer, then output register
// rows: one row per cycle from the row sequencer while the output is not stalled;
// the next cell loads with the last row; samples in grid row or column 0 make no cell
// reset: handshake, counters and corner holds cleared, registers to 40 / 25 / 320;
// the line store is not cleared and is filled by the first grid row of a frame
module bilinear_upscale_by_eight_top #(
	parameter int MAX_GRID_WIDTH = ub8_pkg::MAX_GRID_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ub8_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ub8_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            pixel_0,
	output logic [7:0]                            pixel_1,
	output logic [7:0]                            pixel_2,
	output logic [7:0]                            pixel_3,
	output logic [7:0]                            pixel_4,
	output logic [7:0]                            pixel_5,
	output logic [7:0]                            pixel_6,
	output logic [7:0]                            pixel_7,
	output logic [ub8_pkg::OFFSET_W-1:0]          screen_offset,
	output logic                                  last_row
);

	logic [7:0]           grid_width_q;
	logic [10:0]          grid_height_q;
	logic [15:0]          screen_width_q;
	logic                 load_valid;
	logic                 load_ready;
	ub8_pkg::cell_load_t  load;
	logic [7:0]           pix [ub8_pkg::CELL_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= ub8_pkg::GRID_WIDTH_RST;
			grid_height_q  <= ub8_pkg::GRID_HEIGHT_RST;
			screen_width_q <= ub8_pkg::SCREEN_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ub8_pkg::CFG_GRID_WIDTH:   grid_width_q   <= cfg_data[7:0];
				ub8_pkg::CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data[10:0];
				ub8_pkg::CFG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ub8_front #(
		.MAX_GRID_WIDTH(MAX_GRID_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.load_valid  (load_valid),
		.load_ready  (load_ready),
		.load        (load)
	);

	ub8_rows u_rows (
		.clk           (clk),
		.arst_n        (arst_n),
		.screen_width  (screen_width_q),
		.load_valid    (load_valid),
		.load_ready    (load_ready),
		.load          (load),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pix           (pix),
		.screen_offset (screen_offset),
		.last_row      (last_row)
	);

	assign pixel_0 = pix[0];
	assign pixel_1 = pix[1];
	assign pixel_2 = pix[2];
	assign pixel_3 = pix[3];
	assign pixel_4 = pix[4];
	assign pixel_5 = pix[5];
	assign pixel_6 = pix[6];
	assign pixel_7 = pix[7];

endmodule

/* bench/bilinear_upscale_by_eight_top_tb.sv */
`timescale 1ns / 1ps
module bilinear_upscale_by_eight_top_tb;

	localparam logic [ub8_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_MAX      = 14;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [7:0][7:0]              pix;
		logic [ub8_pkg::OFFSET_W-1:0] offset;
		logic                         last;
	} cell_row_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [ub8_pkg::CFG_IDX_W-1:0]  cfg_index = ub8_pkg::CFG_GRID_WIDTH;
	logic [ub8_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic [7:0]                     sample    = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     pixel_0, pixel_1, pixel_2, pixel_3;
	logic [7:0]                     pixel_4, pixel_5, pixel_6, pixel_7;
	logic [ub8_pkg::OFFSET_W-1:0]   screen_offset;
	logic                           last_row;

	// shadow of the block: registers, line of the previous grid row, corner holds, counters
	logic [7:0]  reg_grid_width   = ub8_pkg::GRID_WIDTH_RST;
	logic [10:0] reg_grid_height  = ub8_pkg::GRID_HEIGHT_RST;
	logic [15:0] reg_screen_width = ub8_pkg::SCREEN_WIDTH_RST;
	logic [7:0]  line_mem [ub8_pkg::MAX_GRID_WIDTH];
	logic [7:0]  corner_ul = '0;
	logic [7:0]  corner_ll = '0;
	int          col_pos   = 0;
	int          row_pos   = 0;

	cell_row_t expected_rows [$];

	int tx_idle_max    = 0;
	int rx_idle_max    = 0;
	int stall_left     = 0;
	int long_hold      = 0;
	int fail_count     = 0;
	int samples_sent   = 0;
	int rows_checked   = 0;
	int settings_count = 0;

	bilinear_upscale_by_eight_top u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int grid_cols(input logic [7:0] w);
		if (w < 2) return 2;
		if (w > ub8_pkg::MAX_GRID_WIDTH) return ub8_pkg::MAX_GRID_WIDTH;
		return int'(w);
	endfunction

	function automatic int grid_rows(input logic [10:0] h);
		if (h < ub8_pkg::MIN_GRID_HEIGHT) return int'(ub8_pkg::MIN_GRID_HEIGHT);
		if (h > ub8_pkg::MAX_GRID_HEIGHT) return int'(ub8_pkg::MAX_GRID_HEIGHT);
		return int'(h);
	endfunction

	// the eight rows of a closed cell, then the store and counter update
	task automatic predict_cell_rows(input logic [7:0] cur);
		int        width, height, tl, tr, bl, br, left, right, step, v, k, l;
		logic [7:0] old_top;
		longint    pos;
		cell_row_t r;
		width   = grid_cols(reg_grid_width);
		height  = grid_rows(reg_grid_height);
		old_top = line_mem[col_pos % ub8_pkg::MAX_GRID_WIDTH];
		if (col_pos > 0 && row_pos > 0) begin
			tl = corner_ul;
			tr = old_top;
			bl = corner_ll;
			br = cur;
			for (k = 0; k < ub8_pkg::CELL_SIZE; k++) begin
				left  = 8 * tl + (bl - tl) * k;
				right = 8 * tr + (br - tr) * k;
				step  = (right - left) >>> 3;
				for (l = 0; l < ub8_pkg::CELL_SIZE; l++) begin
					v = left + l * step;
					if (v < 0) begin
						r.pix[l] = 8'd0;
					end else if ((v >>> 3) > 255) begin
						r.pix[l] = 8'd255;
					end else begin
						r.pix[l] = 8'(v >>> 3);
					end
				end
				pos = longint'(col_pos - 1) * ub8_pkg::CELL_SIZE
					+ longint'((row_pos - 1) * ub8_pkg::CELL_SIZE + k)
					* longint'(reg_screen_width);
				r.offset = pos[ub8_pkg::OFFSET_W-1:0];
				r.last   = (k == ub8_pkg::CELL_SIZE - 1);
				expected_rows.push_back(r);
			end
		end
		corner_ul = old_top;
		line_mem[col_pos % ub8_pkg::MAX_GRID_WIDTH] = cur;
		corner_ll = cur;
		if (col_pos >= width - 1) begin
			col_pos = 0;
			row_pos = (row_pos >= height - 1) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic send_sample(input logic [7:0] value);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cell_rows(value);
		samples_sent++;
	endtask

	task automatic run_samples(input int n);
		repeat (n) send_sample(8'($urandom));
	endtask

	// sender quiet until every expected row is in, then room for a sample with no rows
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ub8_pkg::CFG_IDX_W-1:0] idx,
			input logic [ub8_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			ub8_pkg::CFG_GRID_WIDTH:   reg_grid_width   = data[7:0];
			ub8_pkg::CFG_GRID_HEIGHT:  reg_grid_height  = data[10:0];
			ub8_pkg::CFG_SCREEN_WIDTH: reg_screen_width = data[15:0];
			default: ;
		endcase
	endtask

	// shrink the grid to 2x2 and feed samples until the counters are back at the origin
	task automatic goto_frame_start();
		wait_idle();
		write_reg(ub8_pkg::CFG_GRID_WIDTH, 16'd2);
		write_reg(ub8_pkg::CFG_GRID_HEIGHT, 16'd2);
		while (col_pos != 0 || row_pos != 0) send_sample(8'($urandom));
		wait_idle();
	endtask

	task automatic pick_idling();
		tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
		rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
	endtask

	task automatic apply_settings(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] sw);
		wait_idle();
		// a wider grid mid-frame would read line entries not yet filled in this frame
		if (grid_cols(w[7:0]) > grid_cols(reg_grid_width) && (col_pos != 0 || row_pos != 0))
			goto_frame_start();
		write_reg(ub8_pkg::CFG_GRID_WIDTH, w);
		write_reg(ub8_pkg::CFG_GRID_HEIGHT, h);
		write_reg(ub8_pkg::CFG_SCREEN_WIDTH, sw);
		settings_count++;
	endtask

	task automatic test_reset_defaults();
		pick_idling();
		settings_count++;
		run_samples(42);
		wait_idle();
	endtask

	task automatic test_directed_corners();
		logic [7:0] corners [18];
		int i;
		corners = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
			8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd127};
		goto_frame_start();
		write_reg(ub8_pkg::CFG_GRID_HEIGHT, 16'd16);
		write_reg(ub8_pkg::CFG_SCREEN_WIDTH, 16'd8);
		settings_count++;
		pick_idling();
		for (i = 0; i < 18; i++) send_sample(corners[i]);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		logic [15:0] widths  [4];
		logic [15:0] heights [4];
		logic [15:0] pitches [4];
		int          counts  [4];
		int          i;
		widths  = '{16'd1, 16'hAB81, 16'd2, 16'd5};
		heights = '{16'd0, 16'd3, 16'h07FF, 16'd1};
		pitches = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd7};
		counts  = '{6, 132, 72, 12};
		wait_idle();
		write_reg(CFG_UNUSED, 16'($urandom));
		for (i = 0; i < 4; i++) begin
			apply_settings(widths[i], heights[i], pitches[i]);
			pick_idling();
			run_samples(counts[i]);
		end
		wait_idle();
	endtask

	task automatic test_output_hold();
		apply_settings(16'd4, 16'hFC00, 16'd320);
		tx_idle_max = 0;
		rx_idle_max = 0;
		long_hold   = HOLD_CYCLES;
		run_samples(12);
		wait_idle();
	endtask

	task automatic test_input_pause();
		apply_settings(16'd6, 16'd9, 16'd1000);
		tx_idle_max = IDLE_MAX;
		rx_idle_max = IDLE_MAX;
		run_samples(8);
		wait_idle();
		run_samples(8);
		wait_idle();
	endtask

	initial begin : row_stall_driver
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				stall_left = long_hold;
				long_hold  = 0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : row_checker
		cell_row_t got, want;
		int        l;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.pix    = {pixel_7, pixel_6, pixel_5, pixel_4,
					pixel_3, pixel_2, pixel_1, pixel_0};
				got.offset = screen_offset;
				got.last   = last_row;
				stall_left = $urandom_range(0, rx_idle_max);
				if (expected_rows.size() == 0) begin
					$error("row transaction with nothing expected, offset %0d", got.offset);
					fail_count++;
				end else begin
					want = expected_rows.pop_front();
					rows_checked++;
					for (l = 0; l < ub8_pkg::CELL_SIZE; l++) begin
						if (got.pix[l] !== want.pix[l]) begin
							$error("pixel_%0d: expected %0d, got %0d", l, want.pix[l],
								got.pix[l]);
							fail_count++;
						end
					end
					if (got.offset !== want.offset) begin
						$error("screen_offset: expected %0d, got %0d", want.offset, got.offset);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$error("last_row: expected %0d, got %0d", want.last, got.last);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		foreach (line_mem[i]) line_mem[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_corners();
		test_register_extremes();
		test_output_hold();
		test_input_pause();
		wait_idle();
		$display("%0d samples in, %0d output rows checked over %0d register settings",
			samples_sent, rows_checked, settings_count);
		$display("clamped grid sizes, offset wrap, falling slopes and a long output hold seen");
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ub8_pkg.sv
rtl/core/ub8_front.sv
rtl/core/ub8_rows.sv
rtl/core/bilinear_upscale_by_eight_top.sv
bench/bilinear_upscale_by_eight_top_tb.sv
